// ----- design/timestamp_range_counter_defines.svh -----
// Assertion macros used by the timestamp range counter datapath
`ifndef TIMESTAMP_RANGE_COUNTER_DEFINES_SVH
`define TIMESTAMP_RANGE_COUNTER_DEFINES_SVH

// Clocked check, held off while reset is asserted
`define TRC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define TRC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/trc_pkg.sv -----
// Shared types and constants of the timestamp range counter
`timescale 1ns / 1ps
`default_nettype none
package trc_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int HELD_W      = $clog2(MAX_ENTRIES + 1);
	localparam int COUNT_W     = 11;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	typedef struct packed {
		logic        command;
		logic [15:0] entry_day;
		logic [31:0] entry_time;
		logic [15:0] query_start_day;
		logic [31:0] query_start_time;
		logic [15:0] query_end_day;
		logic [31:0] query_end_time;
	} req_t;

	typedef struct packed {
		logic [COUNT_W-1:0] match_count;
		logic               store_overflowed;
	} rsp_t;

	typedef struct packed {
		logic [15:0] day;
		logic [31:0] tstamp;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic append;
		logic load_query;
		logic issue;
		logic publish;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic more;
		logic pipe_empty;
		logic out_busy;
	} dp_status_t;

endpackage
`default_nettype wire

// ----- design/timestamp_range_counter.sv -----
// Top level of the timestamp range counter
//
// Requests arrive on req_valid / req_stall / req; a request is taken at a
// rising edge with req_valid high and req_stall low. An append request
// (command 0) writes its day and time at the next free slot as it is taken
// and gives no result; once the store holds all its entries, appends are
// dropped and the overflow flag is set until reset.
// A range query (command 1) reads the held entries from the store, one per
// cycle through the single read port, and compares each against the range.
// The result appears on rsp_valid / rsp_stall / rsp once the scan has
// drained through the read and compare stages; req_stall stays high from
// the query's acceptance until its result is placed in the output register.
// The result waits in the output register while rsp_stall is high; the next
// request can be taken meanwhile, but a following query holds in its final
// state until the waiting result has been taken.
// Reset empties the store (held count zero), clears the overflow flag and
// drops any pending result; stored contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module timestamp_range_counter (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire trc_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output trc_pkg::rsp_t      rsp
);

	trc_pkg::ctrl_cmd_t  cmd;
	trc_pkg::dp_status_t status;

	trc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_command (req.command),
		.req_stall   (req_stall),
		.status      (status),
		.cmd         (cmd)
	);

	trc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// ----- design/trc_ctrl.sv -----
// Controller state machine of the timestamp range counter
`timescale 1ns / 1ps
`default_nettype none
module trc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic              req_command,
	output logic                   req_stall,
	input  wire trc_pkg::dp_status_t status,
	output trc_pkg::ctrl_cmd_t     cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_FLUSH = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_command == trc_pkg::CMD_QUERY) begin
						cmd.load_query = 1'b1;
						state_d        = ST_SCAN;
					end else begin
						cmd.append = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (status.more) begin
					cmd.issue = 1'b1;
				end else begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				// wait for the last compare to land in the count
				if (status.pipe_empty) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!status.out_busy) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- design/trc_datapath.sv -----
// Entry store, scan pipeline, match counter and result register
`timescale 1ns / 1ps
`default_nettype none
`include "timestamp_range_counter_defines.svh"
module trc_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire trc_pkg::req_t       req,
	input  wire trc_pkg::ctrl_cmd_t  cmd,
	output trc_pkg::dp_status_t      status,
	input  wire logic                rsp_stall,
	output logic                     rsp_valid,
	output trc_pkg::rsp_t            rsp
);

	trc_pkg::entry_t entry_mem_q [trc_pkg::MAX_ENTRIES];

	logic [trc_pkg::HELD_W-1:0]  held_q;
	logic [trc_pkg::HELD_W-1:0]  scan_q;
	logic [trc_pkg::COUNT_W-1:0] count_q;
	logic                        overflow_q;

	logic [15:0] qry_sd_q;
	logic [31:0] qry_st_q;
	logic [15:0] qry_ed_q;
	logic [31:0] qry_et_q;
	logic        qry_same_q;

	trc_pkg::entry_t rd_data_s1;
	logic            rd_vld_s1;
	logic            hit_s2;
	logic            hit_vld_s2;

	logic            rsp_valid_q;
	trc_pkg::rsp_t   rsp_q;

	logic            store_full;
	logic            hit;

	assign store_full = (held_q == trc_pkg::HELD_W'(trc_pkg::MAX_ENTRIES));

	// range test of one stored entry against the held query
	always_comb begin
		if (qry_same_q) begin
			hit = (rd_data_s1.day == qry_sd_q) && (rd_data_s1.tstamp >= qry_st_q)
				&& (rd_data_s1.tstamp <= qry_et_q);
		end else if ((rd_data_s1.day > qry_sd_q) && (rd_data_s1.day < qry_ed_q)) begin
			hit = 1'b1;
		end else if (rd_data_s1.day == qry_sd_q) begin
			hit = (rd_data_s1.tstamp >= qry_st_q);
		end else if (rd_data_s1.day == qry_ed_q) begin
			hit = (rd_data_s1.tstamp <= qry_et_q);
		end else begin
			hit = 1'b0;
		end
	end

	// store write port
	always_ff @(posedge clk) begin
		if (cmd.append && !store_full) begin
			entry_mem_q[held_q[trc_pkg::ADDR_W-1:0]] <= '{day: req.entry_day,
				tstamp: req.entry_time};
		end
	end

	// store read port
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rd_data_s1 <= entry_mem_q[scan_q[trc_pkg::ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			qry_sd_q   <= req.query_start_day;
			qry_st_q   <= req.query_start_time;
			qry_ed_q   <= req.query_end_day;
			qry_et_q   <= req.query_end_time;
			qry_same_q <= (req.query_start_day == req.query_end_day);
		end
		hit_s2 <= hit;
		if (cmd.publish) begin
			rsp_q <= '{match_count: count_q, store_overflowed: overflow_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			overflow_q  <= 1'b0;
			scan_q      <= '0;
			count_q     <= '0;
			rd_vld_s1   <= 1'b0;
			hit_vld_s2  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.append) begin
				if (store_full) begin
					overflow_q <= 1'b1;
				end else begin
					held_q <= held_q + 1'b1;
				end
			end

			rd_vld_s1  <= cmd.issue;
			hit_vld_s2 <= rd_vld_s1;

			if (cmd.load_query) begin
				scan_q  <= '0;
				count_q <= '0;
			end else begin
				if (cmd.issue) begin
					scan_q <= scan_q + 1'b1;
				end
				// saturate rather than wrap
				if (hit_vld_s2 && hit_s2 && (count_q != trc_pkg::COUNT_MAX)) begin
					count_q <= count_q + 1'b1;
				end
			end

			if (cmd.publish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign status.more       = (scan_q < held_q);
	assign status.pipe_empty = !rd_vld_s1 && !hit_vld_s2;
	assign status.out_busy   = rsp_valid_q && rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`TRC_ASSERT(a_scan_within_held, (scan_q <= held_q), "scan address ran past the held entries")
	`TRC_ASSERT(a_issue_below_held, (cmd.issue |-> (scan_q < held_q)), "read issued beyond held entries")
	`TRC_ASSERT(a_count_le_held, ({1'b0, count_q} <= (trc_pkg::COUNT_W + 1)'(held_q)), "match count exceeds held entries")
	`TRC_ASSERT(a_overflow_sticky, (overflow_q |=> overflow_q), "overflow flag cleared without reset")
	`TRC_ASSERT(a_publish_drained, (cmd.publish |-> status.pipe_empty), "result published with compares in flight")

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the timestamp range counter: appends, range queries, overflow
`timescale 1ns / 1ps
module testbench;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int DRAIN_CYCLES = trc_pkg::MAX_ENTRIES + 64;
	localparam logic [15:0] DAY_MAX = 16'hFFFF;
	localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	trc_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	trc_pkg::rsp_t rsp;

	timestamp_range_counter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Shadow of the block's log store
	trc_pkg::entry_t log_store [trc_pkg::MAX_ENTRIES];
	int held_entries = 0;
	logic overflow_flag = 1'b0;

	trc_pkg::req_t request_queue [$];
	trc_pkg::rsp_t pending_counts [$];
	trc_pkg::rsp_t want;
	int error_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycle_count = 0;

	function automatic logic entry_in_range(trc_pkg::entry_t e, trc_pkg::req_t q);
		if (q.query_start_day == q.query_end_day)
			return e.day == q.query_start_day && e.tstamp >= q.query_start_time &&
				e.tstamp <= q.query_end_time;
		if (e.day > q.query_start_day && e.day < q.query_end_day)
			return 1'b1;
		if (e.day == q.query_start_day)
			return e.tstamp >= q.query_start_time;
		if (e.day == q.query_end_day)
			return e.tstamp <= q.query_end_time;
		return 1'b0;
	endfunction

	// Update the shadow store and queue the count a query should return
	task automatic apply_request(trc_pkg::req_t r);
		int hits;
		trc_pkg::rsp_t res;
		if (r.command == trc_pkg::CMD_APPEND) begin
			if (held_entries < trc_pkg::MAX_ENTRIES) begin
				log_store[held_entries] = '{day: r.entry_day, tstamp: r.entry_time};
				held_entries++;
			end else begin
				overflow_flag = 1'b1;
			end
		end else begin
			hits = 0;
			for (int i = 0; i < held_entries; i++)
				if (entry_in_range(log_store[i], r))
					hits++;
			if (hits > int'(trc_pkg::COUNT_MAX))
				hits = int'(trc_pkg::COUNT_MAX);
			res.match_count = trc_pkg::COUNT_W'(hits);
			res.store_overflowed = overflow_flag;
			pending_counts = {pending_counts, res};
		end
	endtask

	// Add a request at the tail of the pending requests
	task automatic enqueue(trc_pkg::req_t r);
		request_queue = {request_queue, r};
	endtask

	// Ignored fields carry random junk
	function automatic trc_pkg::req_t mk_append(logic [15:0] day, logic [31:0] stamp);
		trc_pkg::req_t r;
		r.command = trc_pkg::CMD_APPEND;
		r.entry_day = day;
		r.entry_time = stamp;
		r.query_start_day = 16'($urandom);
		r.query_start_time = $urandom;
		r.query_end_day = 16'($urandom);
		r.query_end_time = $urandom;
		return r;
	endfunction

	function automatic trc_pkg::req_t mk_query(logic [15:0] sd, logic [31:0] st,
			logic [15:0] ed, logic [31:0] et);
		trc_pkg::req_t r;
		r.command = trc_pkg::CMD_QUERY;
		r.entry_day = 16'($urandom);
		r.entry_time = $urandom;
		r.query_start_day = sd;
		r.query_start_time = st;
		r.query_end_day = ed;
		r.query_end_time = et;
		return r;
	endfunction

	// Keep most days in a narrow window so queries actually hit entries
	function automatic logic [15:0] random_day();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			return 16'($urandom_range(0, 15));
		if (pick == 7)
			return DAY_MAX - 16'($urandom_range(0, 3));
		if (pick == 8)
			return 16'($urandom);
		return 16'h0000;
	endfunction

	function automatic logic [31:0] random_stamp();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			return 32'($urandom_range(0, 63));
		if (pick == 6)
			return TIME_MAX - 32'($urandom_range(0, 3));
		if (pick < 9)
			return $urandom;
		return 32'h0;
	endfunction

	function automatic trc_pkg::req_t random_request();
		logic [15:0] sd;
		logic [15:0] ed;
		if ($urandom_range(0, 99) < 55)
			return mk_append(random_day(), random_stamp());
		sd = random_day();
		ed = ($urandom_range(0, 3) == 0) ? sd : random_day();
		return mk_query(sd, random_stamp(), ed, random_stamp());
	endfunction

	task automatic wait_quiet();
		while (request_queue.size() != 0 || req_valid || pending_counts.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall)
				apply_request(req);
			if (!req_valid || !req_stall) begin
				if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req <= request_queue.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_counts.size() == 0) begin
					$error("unexpected result: match_count %0d store_overflowed %0b",
						rsp.match_count, rsp.store_overflowed);
					error_count++;
				end else begin
					want = pending_counts.pop_front();
					if (rsp.match_count !== want.match_count) begin
						$error("match_count expected %0d actual %0d",
							want.match_count, rsp.match_count);
						error_count++;
					end
					if (rsp.store_overflowed !== want.store_overflowed) begin
						$error("store_overflowed expected %0b actual %0b",
							want.store_overflowed, rsp.store_overflowed);
						error_count++;
					end
				end
			end
			rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int fill;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty store, extreme days and times, time zero, reversed ranges
		enqueue(mk_query(16'h0000, 32'h0, DAY_MAX, TIME_MAX));
		enqueue(mk_append(16'h0000, 32'h0));
		enqueue(mk_append(16'h0000, TIME_MAX));
		enqueue(mk_append(DAY_MAX, 32'h0));
		enqueue(mk_append(DAY_MAX, TIME_MAX));
		enqueue(mk_append(16'd5, 32'd100));
		enqueue(mk_append(16'd5, 32'd200));
		enqueue(mk_append(16'd6, 32'd50));
		enqueue(mk_append(16'd7, 32'd1));
		enqueue(mk_query(16'h0000, 32'h0, DAY_MAX, TIME_MAX));
		enqueue(mk_query(16'd5, 32'd100, 16'd5, 32'd200));
		enqueue(mk_query(16'd5, 32'd150, 16'd5, 32'd100));
		enqueue(mk_query(16'h0000, 32'h0, 16'h0000, 32'h0));
		enqueue(mk_query(DAY_MAX, 32'h0, DAY_MAX, TIME_MAX));
		enqueue(mk_query(16'd7, 32'h0, 16'd5, 32'd150));
		enqueue(mk_query(16'd5, 32'd150, 16'd7, 32'h0));
		enqueue(mk_query(16'h0000, 32'd1, DAY_MAX, TIME_MAX - 32'd1));
		wait_quiet();

		// Random traffic under each idling mix; drain fully between mixes
		for (int mix = 0; mix < 4; mix++) begin
			case (mix)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			for (int n = 0; n < 145; n++)
				enqueue(random_request());
			wait_quiet();
		end

		// Fill the store to the brim, then overflow it
		fill = trc_pkg::MAX_ENTRIES - held_entries;
		for (int n = 0; n < fill; n++)
			enqueue(mk_append(random_day(), random_stamp()));
		enqueue(mk_query(16'h0000, 32'h0, DAY_MAX, TIME_MAX));
		for (int n = 0; n < 5; n++)
			enqueue(mk_append(random_day(), random_stamp()));
		enqueue(mk_query(16'h0000, 32'h0, DAY_MAX, TIME_MAX));
		for (int n = 0; n < 3; n++)
			enqueue(mk_query(random_day(), random_stamp(),
				random_day(), random_stamp()));
		wait_quiet();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+design
design/trc_pkg.sv
design/trc_ctrl.sv
design/trc_datapath.sv
design/timestamp_range_counter.sv
tb/testbench.sv
